@@ rtl/mcb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze carver package
// Shared widths, codes and the direction permutation decoder.
// ----------------------------------------------------------------------------
package mcb_pkg;

  // Fixed port widths
  localparam int COORD_W   = 6;  // coordinate fields on the ports
  localparam int PERM_W    = 5;  // direction_order field
  localparam int OUTCOME_W = 3;
  localparam int CFG_W     = 7;  // widest configuration register
  localparam int CFG_IDX_W = 1;
  localparam int TRIED_W   = 3;  // 0..4 directions tried
  localparam int DIM_W     = 9;  // clamped dimensions, up to 256

  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLS    = 64;
  localparam int DEF_STACK_DEPTH = 1024;

  localparam logic [CFG_W-1:0] DIM_RESET = 7'd9;
  localparam int DIM_MIN  = 5;
  localparam int PERM_CNT = 24;

  // Request types
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_START   = 3'd0,
    OC_CARVED  = 3'd1,
    OC_REFUSED = 3'd2,
    OC_BACK    = 3'd3,
    OC_DONE    = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  // k-th direction of lexicographic permutation p (p already below 24).
  // Word holds direction k at bits [2k+1:2k].
  function automatic dir_t perm_dir(input logic [PERM_W-1:0] p, input logic [1:0] k);
    logic [7:0] w;
    case (p)
      5'd0:    w = {2'd3, 2'd2, 2'd1, 2'd0};
      5'd1:    w = {2'd2, 2'd3, 2'd1, 2'd0};
      5'd2:    w = {2'd3, 2'd1, 2'd2, 2'd0};
      5'd3:    w = {2'd1, 2'd3, 2'd2, 2'd0};
      5'd4:    w = {2'd2, 2'd1, 2'd3, 2'd0};
      5'd5:    w = {2'd1, 2'd2, 2'd3, 2'd0};
      5'd6:    w = {2'd3, 2'd2, 2'd0, 2'd1};
      5'd7:    w = {2'd2, 2'd3, 2'd0, 2'd1};
      5'd8:    w = {2'd3, 2'd0, 2'd2, 2'd1};
      5'd9:    w = {2'd0, 2'd3, 2'd2, 2'd1};
      5'd10:   w = {2'd2, 2'd0, 2'd3, 2'd1};
      5'd11:   w = {2'd0, 2'd2, 2'd3, 2'd1};
      5'd12:   w = {2'd3, 2'd1, 2'd0, 2'd2};
      5'd13:   w = {2'd1, 2'd3, 2'd0, 2'd2};
      5'd14:   w = {2'd3, 2'd0, 2'd1, 2'd2};
      5'd15:   w = {2'd0, 2'd3, 2'd1, 2'd2};
      5'd16:   w = {2'd1, 2'd0, 2'd3, 2'd2};
      5'd17:   w = {2'd0, 2'd1, 2'd3, 2'd2};
      5'd18:   w = {2'd2, 2'd1, 2'd0, 2'd3};
      5'd19:   w = {2'd1, 2'd2, 2'd0, 2'd3};
      5'd20:   w = {2'd2, 2'd0, 2'd1, 2'd3};
      5'd21:   w = {2'd0, 2'd2, 2'd1, 2'd3};
      5'd22:   w = {2'd1, 2'd0, 2'd2, 2'd3};
      5'd23:   w = {2'd0, 2'd1, 2'd2, 2'd3};
      default: w = {2'd3, 2'd2, 2'd1, 2'd0};
    endcase
    return dir_t'(w[{k, 1'b0} +: 2]);
  endfunction

endpackage

@@ rtl/maze_carving_backtracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze carving backtracker
// Depth-first maze carver over a wall-bit map and a frame stack in RAM.
// ----------------------------------------------------------------------------
// One item at a time; each item gives exactly one result. A step with an
// empty stack answers in the cycle after the accept. Other steps pass through
// states in order: frame read (a backtrack answers here), map read of the
// target (a refusal answers here), then one map write port opening target
// and passage in turn for a carve. A start item sweeps the whole wall map
// back to walls, one entry a cycle, 2**(clog2(MAX_ROWS)+clog2(MAX_COLS))
// entries (4096 with defaults), then opens the start cell; the input stalls
// during the sweep. The map is addressed as {row, col}. Before the first
// start the stack is empty, so the map is never read and needs no sweep
// after reset. Config writes are taken at any time but are meant for idle
// periods; dimensions are clamped to 5..MAX when used.
// ----------------------------------------------------------------------------
module maze_carving_backtracker #(
  parameter int MAX_ROWS    = mcb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = mcb_pkg::DEF_MAX_COLS,
  parameter int STACK_DEPTH = mcb_pkg::DEF_STACK_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration
  input  logic                             cfg_we,
  input  logic [mcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcb_pkg::CFG_W-1:0]        cfg_wdata,
  // Request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [mcb_pkg::COORD_W-1:0]      in_start_row,
  input  logic [mcb_pkg::COORD_W-1:0]      in_start_col,
  input  logic [mcb_pkg::PERM_W-1:0]       in_direction_order,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mcb_pkg::OUTCOME_W-1:0]    out_outcome,
  output logic [mcb_pkg::COORD_W-1:0]      out_cell_row,
  output logic [mcb_pkg::COORD_W-1:0]      out_cell_col,
  output logic [mcb_pkg::COORD_W-1:0]      out_passage_row,
  output logic [mcb_pkg::COORD_W-1:0]      out_passage_col
);
  import mcb_pkg::*;

  localparam int RW        = $clog2(MAX_ROWS);
  localparam int CW        = $clog2(MAX_COLS);
  localparam int AW        = RW + CW;
  localparam int MAP_DEPTH = 1 << AW;
  localparam int SAW       = $clog2(STACK_DEPTH);
  localparam int LW        = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic [RW-1:0]      row;
    logic [CW-1:0]      col;
    logic [PERM_W-1:0]  perm;
    logic [TRIED_W-1:0] tried;
  } frame_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,  // sweep map to walls
    ST_OPEN  = 6'b000100,  // open start cell, push first frame
    ST_FRAME = 6'b001000,  // top frame read data available
    ST_TEST  = 6'b010000,  // target map bit available
    ST_PASS  = 6'b100000   // open passage cell, deliver carve
  } state_t;

  // --------------------------------------------------------------------------
  // Control and payload registers
  // --------------------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic [AW-1:0]    sweep_r, sweep_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [RW-1:0]      cur_row_r, cur_row_nxt;   // start cell / top frame
  logic [CW-1:0]      cur_col_r, cur_col_nxt;
  logic [PERM_W-1:0]  perm_r, perm_nxt;         // perm for any pushed frame
  logic [RW-1:0]      tgt_row_r, tgt_row_nxt;
  logic [CW-1:0]      tgt_col_r, tgt_col_nxt;
  logic [RW-1:0]      pas_row_r, pas_row_nxt;
  logic [CW-1:0]      pas_col_r, pas_col_nxt;
  logic               bnd_ok_r, bnd_ok_nxt;

  logic [OUTCOME_W-1:0] out_outcome_r, out_outcome_nxt;
  logic [COORD_W-1:0]   out_cell_row_r, out_cell_row_nxt;
  logic [COORD_W-1:0]   out_cell_col_r, out_cell_col_nxt;
  logic [COORD_W-1:0]   out_pas_row_r, out_pas_row_nxt;
  logic [COORD_W-1:0]   out_pas_col_r, out_pas_col_nxt;

  // --------------------------------------------------------------------------
  // Memories: wall map (1 = wall) and frame stack, registered reads
  // --------------------------------------------------------------------------
  logic          map_mem [MAP_DEPTH];
  logic          map_rdata_r;
  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic          map_wdata;
  logic [AW-1:0] map_raddr;

  frame_t         stk_mem [STACK_DEPTH];
  frame_t         stk_rdata_r;
  logic           stk_we;
  logic [SAW-1:0] stk_waddr;
  frame_t         stk_wdata;
  logic [SAW-1:0] stk_raddr;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata_r <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_r <= stk_mem[stk_raddr];
  end

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic in_xfer;
  logic out_xfer;

  // Output slot must be empty or draining so a same-cycle result fits.
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;

  assign out_valid       = out_valid_r;
  assign out_outcome     = out_outcome_r;
  assign out_cell_row    = out_cell_row_r;
  assign out_cell_col    = out_cell_col_r;
  assign out_passage_row = out_pas_row_r;
  assign out_passage_col = out_pas_col_r;

  // --------------------------------------------------------------------------
  // Clamped dimensions and start coordinates
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]  rows_eff, cols_eff;
  logic [DIM_W-1:0]  row_top, col_top, row_top_odd, col_top_odd;
  logic [DIM_W-1:0]  start_row_odd, start_col_odd;
  logic [DIM_W-1:0]  start_row_cl, start_col_cl;
  logic [PERM_W-1:0] in_perm;

  always_comb begin
    rows_eff = DIM_W'(rows_r);
    if (rows_eff < DIM_W'(DIM_MIN)) begin
      rows_eff = DIM_W'(DIM_MIN);
    end else if (rows_eff > DIM_W'(MAX_ROWS)) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end
    cols_eff = DIM_W'(cols_r);
    if (cols_eff < DIM_W'(DIM_MIN)) begin
      cols_eff = DIM_W'(DIM_MIN);
    end else if (cols_eff > DIM_W'(MAX_COLS)) begin
      cols_eff = DIM_W'(MAX_COLS);
    end
  end

  // Largest odd value not above dim-2; start forced odd then clamped.
  assign row_top       = rows_eff - DIM_W'(2);
  assign col_top       = cols_eff - DIM_W'(2);
  assign row_top_odd   = row_top[0] ? row_top : row_top - DIM_W'(1);
  assign col_top_odd   = col_top[0] ? col_top : col_top - DIM_W'(1);
  assign start_row_odd = DIM_W'(in_start_row) | DIM_W'(1);
  assign start_col_odd = DIM_W'(in_start_col) | DIM_W'(1);
  assign start_row_cl  = (start_row_odd > row_top_odd) ? row_top_odd : start_row_odd;
  assign start_col_cl  = (start_col_odd > col_top_odd) ? col_top_odd : start_col_odd;

  // Permutation index modulo 24
  assign in_perm = (in_direction_order >= PERM_W'(PERM_CNT))
                 ? in_direction_order - PERM_W'(PERM_CNT) : in_direction_order;

  // --------------------------------------------------------------------------
  // Top frame decode (valid in ST_FRAME)
  // --------------------------------------------------------------------------
  frame_t           top_f;
  dir_t             top_dir;
  logic [DIM_W-1:0] top_row_x, top_col_x;

  assign top_f     = stk_rdata_r;
  assign top_dir   = perm_dir(top_f.perm, top_f.tried[1:0]);
  assign top_row_x = DIM_W'(top_f.row);
  assign top_col_x = DIM_W'(top_f.col);

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt        = state_r;
    rows_nxt         = rows_r;
    cols_nxt         = cols_r;
    level_nxt        = level_r;
    sweep_nxt        = sweep_r;
    out_valid_nxt    = out_valid_r && !out_xfer;
    cur_row_nxt      = cur_row_r;
    cur_col_nxt      = cur_col_r;
    perm_nxt         = perm_r;
    tgt_row_nxt      = tgt_row_r;
    tgt_col_nxt      = tgt_col_r;
    pas_row_nxt      = pas_row_r;
    pas_col_nxt      = pas_col_r;
    bnd_ok_nxt       = bnd_ok_r;
    out_outcome_nxt  = out_outcome_r;
    out_cell_row_nxt = out_cell_row_r;
    out_cell_col_nxt = out_cell_col_r;
    out_pas_row_nxt  = out_pas_row_r;
    out_pas_col_nxt  = out_pas_col_r;

    map_we    = 1'b0;
    map_waddr = '0;
    map_wdata = 1'b0;
    map_raddr = {tgt_row_r, tgt_col_r};
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = SAW'(level_r - LW'(1));

    if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_nxt = cfg_wdata;
        CFG_COLS: cols_nxt = cfg_wdata;
        default:  rows_nxt = rows_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          perm_nxt = in_perm;
          if (in_req_type == REQ_START) begin
            cur_row_nxt = RW'(start_row_cl);
            cur_col_nxt = CW'(start_col_cl);
            sweep_nxt   = '0;
            state_nxt   = ST_CLEAR;
          end else if (level_r == '0) begin
            // finished: nothing left on the stack
            out_valid_nxt    = 1'b1;
            out_outcome_nxt  = OC_DONE;
            out_cell_row_nxt = '0;
            out_cell_col_nxt = '0;
            out_pas_row_nxt  = '0;
            out_pas_col_nxt  = '0;
          end else begin
            // stk_raddr already points at the top frame
            state_nxt = ST_FRAME;
          end
        end
      end

      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = sweep_r;
        map_wdata = 1'b1;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == {AW{1'b1}}) begin
          state_nxt = ST_OPEN;
        end
      end

      ST_OPEN: begin
        map_we           = 1'b1;
        map_waddr        = {cur_row_r, cur_col_r};
        map_wdata        = 1'b0;
        stk_we           = 1'b1;
        stk_waddr        = '0;
        stk_wdata        = '{row: cur_row_r, col: cur_col_r, perm: perm_r, tried: '0};
        level_nxt        = LW'(1);
        out_valid_nxt    = 1'b1;
        out_outcome_nxt  = OC_START;
        out_cell_row_nxt = COORD_W'(cur_row_r);
        out_cell_col_nxt = COORD_W'(cur_col_r);
        out_pas_row_nxt  = '0;
        out_pas_col_nxt  = '0;
        state_nxt        = ST_IDLE;
      end

      ST_FRAME: begin
        cur_row_nxt = top_f.row;
        cur_col_nxt = top_f.col;
        if (top_f.tried[TRIED_W-1]) begin
          // all four tried: pop
          level_nxt        = level_r - LW'(1);
          out_valid_nxt    = 1'b1;
          out_outcome_nxt  = OC_BACK;
          out_cell_row_nxt = COORD_W'(top_f.row);
          out_cell_col_nxt = COORD_W'(top_f.col);
          out_pas_row_nxt  = '0;
          out_pas_col_nxt  = '0;
          state_nxt        = ST_IDLE;
        end else begin
          // write back tried count, fetch target map bit
          stk_we          = 1'b1;
          stk_waddr       = SAW'(level_r - LW'(1));
          stk_wdata       = top_f;
          stk_wdata.tried = top_f.tried + TRIED_W'(1);
          tgt_row_nxt     = top_f.row;
          tgt_col_nxt     = top_f.col;
          pas_row_nxt     = top_f.row;
          pas_col_nxt     = top_f.col;
          case (top_dir)
            DIR_UP: begin
              bnd_ok_nxt  = top_row_x > DIM_W'(2);
              tgt_row_nxt = top_f.row - RW'(2);
              pas_row_nxt = top_f.row - RW'(1);
            end
            DIR_RIGHT: begin
              bnd_ok_nxt  = (top_col_x + DIM_W'(3)) < cols_eff;
              tgt_col_nxt = top_f.col + CW'(2);
              pas_col_nxt = top_f.col + CW'(1);
            end
            DIR_DOWN: begin
              bnd_ok_nxt  = (top_row_x + DIM_W'(3)) < rows_eff;
              tgt_row_nxt = top_f.row + RW'(2);
              pas_row_nxt = top_f.row + RW'(1);
            end
            default: begin
              bnd_ok_nxt  = top_col_x > DIM_W'(2);
              tgt_col_nxt = top_f.col - CW'(2);
              pas_col_nxt = top_f.col - CW'(1);
            end
          endcase
          map_raddr = {tgt_row_nxt, tgt_col_nxt};
          state_nxt = ST_TEST;
        end
      end

      ST_TEST: begin
        if (bnd_ok_r && map_rdata_r && (level_r < LW'(STACK_DEPTH))) begin
          map_we    = 1'b1;
          map_waddr = {tgt_row_r, tgt_col_r};
          map_wdata = 1'b0;
          stk_we    = 1'b1;
          stk_waddr = SAW'(level_r);
          stk_wdata = '{row: tgt_row_r, col: tgt_col_r, perm: perm_r, tried: '0};
          level_nxt = level_r + LW'(1);
          state_nxt = ST_PASS;
        end else begin
          // out of bounds, already open, or stack full
          out_valid_nxt    = 1'b1;
          out_outcome_nxt  = OC_REFUSED;
          out_cell_row_nxt = COORD_W'(cur_row_r);
          out_cell_col_nxt = COORD_W'(cur_col_r);
          out_pas_row_nxt  = '0;
          out_pas_col_nxt  = '0;
          state_nxt        = ST_IDLE;
        end
      end

      ST_PASS: begin
        map_we           = 1'b1;
        map_waddr        = {pas_row_r, pas_col_r};
        map_wdata        = 1'b0;
        out_valid_nxt    = 1'b1;
        out_outcome_nxt  = OC_CARVED;
        out_cell_row_nxt = COORD_W'(tgt_row_r);
        out_cell_col_nxt = COORD_W'(tgt_col_r);
        out_pas_row_nxt  = COORD_W'(pas_row_r);
        out_pas_col_nxt  = COORD_W'(pas_col_r);
        state_nxt        = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_r      <= DIM_RESET;
      cols_r      <= DIM_RESET;
      level_r     <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      level_r     <= level_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_row_r      <= cur_row_nxt;
    cur_col_r      <= cur_col_nxt;
    perm_r         <= perm_nxt;
    tgt_row_r      <= tgt_row_nxt;
    tgt_col_r      <= tgt_col_nxt;
    pas_row_r      <= pas_row_nxt;
    pas_col_r      <= pas_col_nxt;
    bnd_ok_r       <= bnd_ok_nxt;
    out_outcome_r  <= out_outcome_nxt;
    out_cell_row_r <= out_cell_row_nxt;
    out_cell_col_r <= out_cell_col_nxt;
    out_pas_row_r  <= out_pas_row_nxt;
    out_pas_col_r  <= out_pas_col_nxt;
  end

endmodule

@@ bench/maze_carving_backtracker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze carving backtracker testbench
// Drives start and step requests through the valid/stall request channel,
// predicts every result with a behavioral copy of the carver (wall map,
// frame stack, grid registers) and checks each result transfer field by
// field. A short directed table runs first, then phases of random starts and
// steps over several grid sizes, with random idling on both channels but the last.
// ----------------------------------------------------------------------------
module maze_carving_backtracker_tb;
  import mcb_pkg::*;

  localparam int MAP_ROWS     = DEF_MAX_ROWS;
  localparam int MAP_COLS     = DEF_MAX_COLS;
  localparam int FRAME_DEPTH  = DEF_STACK_DEPTH;
  localparam int ITEM_TARGET  = 1150;   // directed rows plus random requests
  localparam int IDLE_LIMIT   = 20000;  // outlasts the start sweep of the full map
  localparam int DRAIN_CYCLES = 8;      // outlasts the longest step

  // One result as it leaves the block
  typedef struct {
    outcome_t   outcome;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic [5:0] passage_row;
    logic [5:0] passage_col;
  } carve_result_t;

  // One frame of the depth-first search
  typedef struct {
    int row;
    int col;
    int perm;
    int tried;
  } carve_frame_t;

  // One row of the directed table
  typedef struct {
    logic          req;
    logic [5:0]    srow;
    logic [5:0]    scol;
    logic [4:0]    order;
    bit            typed;
    carve_result_t want;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_req_type = REQ_STEP;
  logic [COORD_W-1:0]   in_start_row = '0;
  logic [COORD_W-1:0]   in_start_col = '0;
  logic [PERM_W-1:0]    in_direction_order = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [COORD_W-1:0]   out_cell_row;
  logic [COORD_W-1:0]   out_cell_col;
  logic [COORD_W-1:0]   out_passage_row;
  logic [COORD_W-1:0]   out_passage_col;

  maze_carving_backtracker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_start_row       (in_start_row),
    .in_start_col       (in_start_col),
    .in_direction_order (in_direction_order),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_outcome        (out_outcome),
    .out_cell_row       (out_cell_row),
    .out_cell_col       (out_cell_col),
    .out_passage_row    (out_passage_row),
    .out_passage_col    (out_passage_col)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: its own wall map, frame stack and grid registers
  // --------------------------------------------------------------------------
  bit            wall_bit [0:MAP_ROWS-1][0:MAP_COLS-1];
  carve_frame_t  frame_mem [0:FRAME_DEPTH-1];
  int            frame_cnt = 0;
  logic [6:0]    dim_rows = DIM_RESET;
  logic [6:0]    dim_cols = DIM_RESET;

  carve_result_t pending_results [$];
  stim_row_t     stim_tab [$];

  // Typed expectation of the row on the bus; driven with the payload so the
  // scoreboard sees the value that belongs to the transfer
  bit            row_typed = 1'b0;
  carve_result_t row_want;

  int err_count = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int phase_count = 0;
  int oc_seen [0:4];
  int send_idle_pct = 16;
  int rcv_idle_pct = 77;

  task automatic clear_map();
    for (int i = 0; i < MAP_ROWS; i++)
      for (int j = 0; j < MAP_COLS; j++)
        wall_bit[i][j] = 1'b1;
  endtask

  // Registers are clamped when used
  function automatic int used_dim(int v, int hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // Start coordinate: force odd, then clamp to the last odd inner cell
  function automatic int odd_start(int v, int dim);
    int top;
    top = dim - 2;
    if (top % 2 == 0) top = top - 1;
    v = v | 1;
    return (v > top) ? top : v;
  endfunction

  // k-th direction of lexicographic permutation p of up,right,down,left
  function automatic int dir_of(int p, int k);
    int avail [4];
    int fact [4];
    int n, idx, pick;
    avail[0] = 0; avail[1] = 1; avail[2] = 2; avail[3] = 3;
    fact[0] = 6;  fact[1] = 2;  fact[2] = 1;  fact[3] = 1;
    n = 4;
    pick = 0;
    for (int i = 0; i <= k && i < 4; i++) begin
      idx = p / fact[i];
      p = p % fact[i];
      if (idx >= n) idx = n - 1;
      pick = avail[idx];
      for (int j = idx; j + 1 < n; j++) avail[j] = avail[j + 1];
      n--;
    end
    return pick;
  endfunction

  function automatic carve_result_t mk_result(outcome_t oc, int r, int c, int pr, int pc);
    carve_result_t res;
    res.outcome     = oc;
    res.cell_row    = 6'(r);
    res.cell_col    = 6'(c);
    res.passage_row = 6'(pr);
    res.passage_col = 6'(pc);
    return res;
  endfunction

  // Advance the predicted carver by one accepted request
  task automatic carve_predict(input logic req, input logic [5:0] srow,
                               input logic [5:0] scol, input logic [4:0] order,
                               output carve_result_t res);
    int  rows, cols, perm, top_i, r, c, tr, tc, pr, pc;
    bit  ok;
    rows = used_dim(dim_rows, MAP_ROWS);
    cols = used_dim(dim_cols, MAP_COLS);
    perm = order % PERM_CNT;
    if (req == REQ_START) begin
      r = odd_start(srow, rows);
      c = odd_start(scol, cols);
      clear_map();
      wall_bit[r][c] = 1'b0;
      frame_mem[0] = '{row: r, col: c, perm: perm, tried: 0};
      frame_cnt = 1;
      res = mk_result(OC_START, r, c, 0, 0);
    end else if (frame_cnt == 0) begin
      res = mk_result(OC_DONE, 0, 0, 0, 0);
    end else begin
      top_i = frame_cnt - 1;
      r = frame_mem[top_i].row;
      c = frame_mem[top_i].col;
      if (frame_mem[top_i].tried >= 4) begin
        // all four tried: pop and report the popped frame
        frame_cnt--;
        res = mk_result(OC_BACK, r, c, 0, 0);
      end else begin
        tr = r; tc = c; pr = r; pc = c;
        case (dir_t'(dir_of(frame_mem[top_i].perm, frame_mem[top_i].tried)))
          DIR_UP: begin
            ok = (r - 2 > 0); tr = r - 2; pr = r - 1;
          end
          DIR_RIGHT: begin
            ok = (c + 2 < cols - 1); tc = c + 2; pc = c + 1;
          end
          DIR_DOWN: begin
            ok = (r + 2 < rows - 1); tr = r + 2; pr = r + 1;
          end
          default: begin
            ok = (c - 2 > 0); tc = c - 2; pc = c - 1;
          end
        endcase
        frame_mem[top_i].tried++;
        // map is only looked at once the target is known to be in bounds;
        // a full stack refuses a direction that could carve
        if (ok) ok = wall_bit[tr][tc] && (frame_cnt < FRAME_DEPTH);
        if (!ok) begin
          res = mk_result(OC_REFUSED, r, c, 0, 0);
        end else begin
          wall_bit[tr][tc] = 1'b0;
          wall_bit[pr][pc] = 1'b0;
          frame_mem[frame_cnt] = '{row: tr, col: tc, perm: perm, tried: 0};
          frame_cnt++;
          res = mk_result(OC_CARVED, tr, tc, pr, pc);
        end
      end
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, redrawn every cycle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Scoreboard. Register writes, request transfers and result transfers are
  // all taken here, in that order, so a result that leaves in the same cycle
  // as its request always finds its expectation queued. Also the watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    carve_result_t pred;
    carve_result_t want;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_we) begin
        moved = 1'b1;
        if (cfg_index == CFG_ROWS) dim_rows = cfg_wdata;
        else dim_cols = cfg_wdata;
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        // the predictor always advances; typed rows override its answer
        carve_predict(in_req_type, in_start_row, in_start_col, in_direction_order, pred);
        pending_results.push_back(row_typed ? row_want : pred);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, outcome", out_outcome, -1);
        end else begin
          want = pending_results.pop_front();
          if (out_outcome != want.outcome)
            report_mismatch("outcome", out_outcome, want.outcome);
          if (out_cell_row != want.cell_row)
            report_mismatch("cell_row", out_cell_row, want.cell_row);
          if (out_cell_col != want.cell_col)
            report_mismatch("cell_col", out_cell_col, want.cell_col);
          if (out_passage_row != want.passage_row)
            report_mismatch("passage_row", out_passage_row, want.passage_row);
          if (out_passage_col != want.passage_col)
            report_mismatch("passage_col", out_passage_col, want.passage_col);
          if (out_outcome <= OC_DONE) oc_seen[out_outcome]++;
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                 $realtime, IDLE_LIMIT, pending_results.size());
        $display("maze_carving_backtracker_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Present one request and hold it until the transfer. Idle cycles come
  // before the request only, so a stalled payload never changes.
  task automatic send_item(input logic req, input logic [5:0] srow, input logic [5:0] scol,
                           input logic [4:0] order, input bit typed,
                           input carve_result_t want);
    // idling profile: sender light/receiver heavy, swapped, then none
    if (items_sent < 400) begin
      send_idle_pct = 16; rcv_idle_pct = 77;
    end else if (items_sent < 800) begin
      send_idle_pct = 77; rcv_idle_pct = 16;
    end else begin
      send_idle_pct = 0;  rcv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_req_type        <= req;
    in_start_row       <= srow;
    in_start_col       <= scol;
    in_direction_order <= order;
    row_typed          <= typed;
    row_want           <= want;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_random(input logic req);
    send_item(req, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              5'($urandom_range(0, 31)), 1'b0, mk_result(OC_DONE, 0, 0, 0, 0));
  endtask

  // Hold off until every expected result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Both grid registers, back to back; only called with the block idle
  task automatic set_grid(input int rows, input int cols);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_wdata <= 7'(rows);
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_wdata <= 7'(cols);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic void add_row(logic req, int srow, int scol, int order, bit typed,
                                  carve_result_t want);
    stim_row_t row;
    row.req   = req;
    row.srow  = 6'(srow);
    row.scol  = 6'(scol);
    row.order = 5'(order);
    row.typed = typed;
    row.want  = want;
    stim_tab.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    carve_result_t none;
    int            rows, cols, steps;
    none = mk_result(OC_DONE, 0, 0, 0, 0);
    foreach (oc_seen[i]) oc_seen[i] = 0;
    clear_map();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, default 9x9 grid. Typed rows: step on an empty stack,
    // start at both coordinate extremes, start with even coordinates and an
    // order index past 23, start with the column clamped.
    add_row(REQ_STEP,  63, 63,  0, 1'b1, mk_result(OC_DONE, 0, 0, 0, 0));
    add_row(REQ_START,  0,  0,  0, 1'b1, mk_result(OC_START, 1, 1, 0, 0));
    add_row(REQ_START, 63, 63, 23, 1'b1, mk_result(OC_START, 7, 7, 0, 0));
    add_row(REQ_START,  2,  4, 31, 1'b1, mk_result(OC_START, 3, 5, 0, 0));
    add_row(REQ_STEP,   0, 63,  0, 1'b0, none);
    add_row(REQ_STEP,  63,  0,  5, 1'b0, none);
    add_row(REQ_STEP,   0,  0, 12, 1'b0, none);
    add_row(REQ_STEP,  63, 63, 17, 1'b0, none);
    add_row(REQ_STEP,  21, 42, 23, 1'b0, none);
    add_row(REQ_STEP,  42, 21, 24, 1'b0, none);
    add_row(REQ_STEP,   0,  0, 31, 1'b0, none);
    add_row(REQ_STEP,  63, 63,  9, 1'b0, none);
    add_row(REQ_STEP,   5, 10, 14, 1'b0, none);
    add_row(REQ_STEP,  10,  5, 20, 1'b0, none);
    add_row(REQ_START,  6, 63,  0, 1'b1, mk_result(OC_START, 7, 7, 0, 0));
    add_row(REQ_STEP,   0,  0,  1, 1'b0, none);
    add_row(REQ_STEP,   0,  0,  2, 1'b0, none);
    add_row(REQ_STEP,   0,  0,  3, 1'b0, none);
    add_row(REQ_STEP,   0,  0,  4, 1'b0, none);
    add_row(REQ_STEP,   0,  0,  6, 1'b0, none);
    add_row(REQ_STEP,   0,  0,  8, 1'b0, none);
    add_row(REQ_STEP,   0,  0, 10, 1'b0, none);
    add_row(REQ_STEP,   0,  0, 11, 1'b0, none);
    add_row(REQ_STEP,   0,  0, 13, 1'b0, none);
    add_row(REQ_STEP,   0,  0, 15, 1'b0, none);
    foreach (stim_tab[i])
      send_item(stim_tab[i].req, stim_tab[i].srow, stim_tab[i].scol,
                stim_tab[i].order, stim_tab[i].typed, stim_tab[i].want);
    drain_results();

    // Random phases. Each phase writes both registers with the block idle,
    // usually starts a fresh maze, then steps it. A phase without a start
    // keeps carving the old maze under the new bounds. Small grids dominate
    // so that mazes run to completion and pop back to an empty stack.
    while (items_sent < ITEM_TARGET) begin
      case (phase_count)
        0: begin rows = 5;   cols = 5;   end
        1: begin rows = 64;  cols = 64;  end
        2: begin rows = 0;   cols = 127; end   // both clamp to their limits
        3: begin rows = 127; cols = 0;   end
        4: begin rows = 5;   cols = 64;  end
        5: begin rows = 64;  cols = 5;   end
        default: begin
          if ($urandom_range(0, 99) < 75) begin
            rows = $urandom_range(5, 15);
            cols = $urandom_range(5, 15);
          end else begin
            rows = $urandom_range(0, 127);
            cols = $urandom_range(0, 127);
          end
        end
      endcase
      set_grid(rows, cols);
      if ($urandom_range(0, 99) < 80) send_random(REQ_START);
      steps = (rows >= 40 || cols >= 40) ? 60 : $urandom_range(30, 90);
      for (int k = 0; k < steps && items_sent < ITEM_TARGET; k++) begin
        // occasional restart mid-maze, and an occasional full hold-off
        if ($urandom_range(0, 99) < 3) send_random(REQ_START);
        else send_random(REQ_STEP);
        if ($urandom_range(0, 99) < 2) drain_results();
      end
      drain_results();
      phase_count++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests in %0d grid phases with %0d register writes.",
             items_sent, phase_count, cfg_writes);
    $display("Results: %0d start, %0d carved, %0d refused, %0d backtracked, %0d finished.",
             oc_seen[OC_START], oc_seen[OC_CARVED], oc_seen[OC_REFUSED],
             oc_seen[OC_BACK], oc_seen[OC_DONE]);
    if (err_count == 0) begin
      $display("maze_carving_backtracker_tb: PASS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("maze_carving_backtracker_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mcb_pkg.sv
rtl/maze_carving_backtracker.sv
bench/maze_carving_backtracker_tb.sv
